@@ design/mbsu_pkg.sv @@
`default_nettype none
package mbsu_pkg;

    // Input item kinds
    localparam logic [2:0] K_LOAD_CPL  = 3'd0;
    localparam logic [2:0] K_LOAD_FLD  = 3'd1;
    localparam logic [2:0] K_STEP      = 3'd2;
    localparam logic [2:0] K_READ_SITE = 3'd3;
    localparam logic [2:0] K_READ_PAIR = 3'd4;

    localparam int VAL_W = 16;   // Q8.8 coupling / field
    localparam int CNT_W = 32;   // occupancy counters
    localparam int SUM_W = 24;   // field + up to 127 couplings
    localparam int ACC_W = 25;   // Q24 probability accumulator, holds 1.0
    localparam int EXP_W = 24;

    localparam logic [ACC_W-1:0] ONE_Q24  = ACC_W'(25'h100_0000);
    localparam logic [48:0]      HALF_Q24 = 49'h80_0000;
    localparam logic [CNT_W-1:0] CNT_SAT  = '1;

    // round(2^24 * exp(-2^k / 256))
    function automatic logic [EXP_W-1:0] exp_q24(input logic [3:0] k);
        logic [EXP_W-1:0] e;
        unique case (k)
            4'd0:    e = 24'd16711808;
            4'd1:    e = 24'd16646655;
            4'd2:    e = 24'd16517109;
            4'd3:    e = 24'd16261035;
            4'd4:    e = 24'd15760736;
            4'd5:    e = 24'd14805841;
            4'd6:    e = 24'd13066109;
            4'd7:    e = 24'd10175896;
            4'd8:    e = 24'd6171993;
            4'd9:    e = 24'd2270549;
            4'd10:   e = 24'd307285;
            4'd11:   e = 24'd5628;
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

@@ design/mbsu_ram.sv @@
`default_nettype none
module mbsu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ design/metropolis_binary_spin_update_unit.sv @@
`default_nettype none
// Metropolis spin update unit, binary spins.
// Input channel (i_in_valid / o_in_stall) takes one item: a coupling load, a
// field load, an update step on a site, or a site / pair count read. Each
// item gives exactly one result item on the output channel (o_out_valid /
// i_out_stall): accepted flag, spin of the addressed site, count.
// One item is worked on at a time; o_in_stall is high while it is in flight.
// An update step walks the coupling column on one memory read port, runs the
// exp() product chain (one multiply a cycle), and does read-modify-write
// over the pair counter rows; N = min(SITES,128).
// A finished result sits in the output register; the next item is taken
// while it waits, but its own result holds until the receiver takes the
// earlier one. A stalled output holds its payload.
// After reset a clearing pass zeroes the whole coupling memory and, while
// its address is below N, the field and counter memories; o_in_stall is
// high during it.
module metropolis_binary_spin_update_unit #(
    parameter int SITES = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_kind,
    input  wire logic [6:0]  i_site,
    input  wire logic [6:0]  i_partner,
    input  wire logic signed [15:0] i_value,
    input  wire logic [15:0] i_uniform,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_accepted,
    output logic             o_spin_now,
    output logic [31:0]      o_count_out
);

    // At most 128 sites are addressable; sites beyond stay zero and unseen.
    localparam int NS = (SITES < 128) ? SITES : 128;
    localparam int AW = $clog2(NS);
    localparam int CW = $clog2(NS * NS);
    localparam int CNT_W = mbsu_pkg::CNT_W;
    localparam int ROW_W = NS * CNT_W;
    localparam logic [AW-1:0] LAST = AW'(NS - 1);
    localparam logic [CW-1:0] CLR_LAST = CW'(NS * NS - 1);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_FLD, S_SUM, S_DE, S_EXP, S_CMP, S_CNTI, S_CNT, S_RD, S_RES
    } t_state;

    t_state r_state;

    logic [2:0]  r_kind;
    logic [6:0]  r_site;
    logic [6:0]  r_partner;
    logic [15:0] r_uni;
    logic        r_site_ok;
    logic        r_pt_ok;
    logic [NS-1:0] r_spins;
    logic [CW-1:0] r_clr;
    logic [AW-1:0] r_cnt;
    logic [CW-1:0] r_addr;
    logic          r_issue;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_j;
    logic signed [mbsu_pkg::SUM_W-1:0] r_sum;
    logic signed [mbsu_pkg::SUM_W:0]   r_de;
    logic [mbsu_pkg::ACC_W-1:0]        r_acc;
    logic [3:0]    r_k;
    logic          r_flip;
    logic [CNT_W-1:0] r_count;

    // memory ports
    logic              cpl_we;
    logic [CW-1:0]     cpl_waddr;
    logic [15:0]       cpl_wdata;
    logic [15:0]       cpl_rdata;
    logic              fld_we;
    logic [AW-1:0]     fld_waddr;
    logic [15:0]       fld_rdata;
    logic              cnt_we;
    logic [AW-1:0]     cnt_waddr;
    logic [AW-1:0]     cnt_raddr;
    logic [CNT_W-1:0]  site_wdata;
    logic [CNT_W-1:0]  site_rdata;
    logic [ROW_W-1:0]  pair_wdata;
    logic [ROW_W-1:0]  pair_rdata;

    logic in_accept;
    logic in_site_ok;
    logic in_pt_ok;
    logic clr_small;
    logic spin_st;
    logic row_spin;
    logic signed [mbsu_pkg::SUM_W:0] n_de;
    logic [48:0] prod;
    logic [16:0] prob;
    logic [AW-1:0] site_idx;
    logic [AW-1:0] pt_idx;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_site_ok = ({1'b0, i_site} < 8'(NS));
    assign in_pt_ok   = ({1'b0, i_partner} < 8'(NS));
    assign clr_small  = (r_clr < CW'(NS));
    assign site_idx   = r_site[AW-1:0];
    assign pt_idx     = r_partner[AW-1:0];
    assign spin_st    = r_spins[site_idx];
    assign row_spin   = r_spins[r_rd_j];

    // deltaE = (s_new - s_old) * local field
    always_comb begin
        n_de = spin_st ? -{r_sum[mbsu_pkg::SUM_W-1], r_sum}
                       :  {r_sum[mbsu_pkg::SUM_W-1], r_sum};
    end

    assign prod = 49'(r_acc) * 49'(mbsu_pkg::exp_q24(r_k)) + mbsu_pkg::HALF_Q24;
    assign prob = 17'((26'(r_acc) + 26'd128) >> 8);

    always_comb begin
        cpl_we    = 1'b0;
        cpl_waddr = CW'(i_site[AW-1:0]) * CW'(NS) + CW'(i_partner[AW-1:0]);
        cpl_wdata = i_value;
        fld_we    = 1'b0;
        fld_waddr = i_site[AW-1:0];
        cnt_we    = 1'b0;
        cnt_waddr = r_rd_j;
        cnt_raddr = (r_state == S_IDLE) ? i_site[AW-1:0] : r_cnt;
        if (r_state == S_CLR) begin
            cpl_we    = 1'b1;
            cpl_waddr = r_clr;
            cpl_wdata = '0;
            fld_we    = clr_small;
            fld_waddr = r_clr[AW-1:0];
            cnt_we    = clr_small;
            cnt_waddr = r_clr[AW-1:0];
        end else if (in_accept && in_site_ok) begin
            cpl_we = (i_kind == mbsu_pkg::K_LOAD_CPL) && in_pt_ok;
            fld_we = (i_kind == mbsu_pkg::K_LOAD_FLD);
        end else if (r_state == S_CNT) begin
            cnt_we = r_rd_vld;
        end
    end

    // saturating increments of one counter row
    always_comb begin
        if (r_state == S_CLR) begin
            site_wdata = '0;
            pair_wdata = '0;
        end else begin
            site_wdata = site_rdata;
            if (row_spin && site_rdata != mbsu_pkg::CNT_SAT) begin
                site_wdata = site_rdata + CNT_W'(1);
            end
            for (int k = 0; k < NS; k++) begin
                pair_wdata[k*CNT_W +: CNT_W] = pair_rdata[k*CNT_W +: CNT_W];
                if (row_spin && r_spins[k]
                        && pair_rdata[k*CNT_W +: CNT_W] != mbsu_pkg::CNT_SAT) begin
                    pair_wdata[k*CNT_W +: CNT_W] =
                        pair_rdata[k*CNT_W +: CNT_W] + CNT_W'(1);
                end
            end
        end
    end

    mbsu_ram #(.WIDTH(16), .DEPTH(NS * NS)) u_cpl (
        .i_clk  (i_clk),
        .i_we   (cpl_we),
        .i_waddr(cpl_waddr),
        .i_wdata(cpl_wdata),
        .i_raddr(r_addr),
        .o_rdata(cpl_rdata)
    );

    mbsu_ram #(.WIDTH(16), .DEPTH(NS)) u_fld (
        .i_clk  (i_clk),
        .i_we   (fld_we),
        .i_waddr(fld_waddr),
        .i_wdata((r_state == S_CLR) ? 16'd0 : i_value),
        .i_raddr(i_site[AW-1:0]),
        .o_rdata(fld_rdata)
    );

    mbsu_ram #(.WIDTH(CNT_W), .DEPTH(NS)) u_site_cnt (
        .i_clk  (i_clk),
        .i_we   (cnt_we),
        .i_waddr(cnt_waddr),
        .i_wdata(site_wdata),
        .i_raddr(cnt_raddr),
        .o_rdata(site_rdata)
    );

    mbsu_ram #(.WIDTH(ROW_W), .DEPTH(NS)) u_pair_cnt (
        .i_clk  (i_clk),
        .i_we   (cnt_we),
        .i_waddr(cnt_waddr),
        .i_wdata(pair_wdata),
        .i_raddr(cnt_raddr),
        .o_rdata(pair_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_spins     <= '0;
            r_issue     <= 1'b0;
            r_rd_vld    <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            // S_RES loads the next result itself
            if (o_out_valid && !i_out_stall && r_state != S_RES) begin
                o_out_valid <= 1'b0;
            end

            // column / row walk: issue one read a cycle, its data arrives in the next cycle
            if (r_state == S_FLD || r_state == S_SUM || r_state == S_CNT) begin
                r_rd_vld <= r_issue;
                r_rd_j   <= r_cnt;
                if (r_issue) begin
                    if (r_cnt == LAST) begin
                        r_issue <= 1'b0;
                    end else begin
                        r_cnt  <= r_cnt + AW'(1);
                        r_addr <= r_addr + CW'(NS);
                    end
                end
            end

            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + CW'(1);
                    if (r_clr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_kind    <= i_kind;
                        r_site    <= i_site;
                        r_partner <= i_partner;
                        r_uni     <= i_uniform;
                        r_site_ok <= in_site_ok;
                        r_pt_ok   <= in_pt_ok;
                        r_cnt     <= '0;
                        r_addr    <= CW'(i_site[AW-1:0]);
                        r_issue   <= 1'b1;
                        r_rd_vld  <= 1'b0;
                        r_flip    <= 1'b0;
                        r_count   <= '0;
                        if (!in_site_ok) begin
                            r_state <= S_RES;
                        end else if (i_kind == mbsu_pkg::K_STEP) begin
                            r_state <= S_FLD;
                        end else if (i_kind == mbsu_pkg::K_READ_SITE
                                || i_kind == mbsu_pkg::K_READ_PAIR) begin
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_RES;
                        end
                    end
                end
                S_FLD: begin
                    r_sum   <= {{(mbsu_pkg::SUM_W-16){fld_rdata[15]}}, fld_rdata};
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (r_rd_vld && r_rd_j != site_idx && row_spin) begin
                        r_sum <= r_sum
                            + {{(mbsu_pkg::SUM_W-16){cpl_rdata[15]}}, cpl_rdata};
                    end
                    if (r_rd_vld && r_rd_j == LAST) begin
                        r_state <= S_DE;
                    end
                end
                S_DE: begin
                    r_de  <= n_de;
                    r_acc <= mbsu_pkg::ONE_Q24;
                    r_k   <= '0;
                    if (n_de[mbsu_pkg::SUM_W]) begin
                        r_flip  <= 1'b1;        // energy drops: always flip
                        r_state <= S_CNTI;
                    end else if (n_de[mbsu_pkg::SUM_W-1:12] != '0) begin
                        r_state <= S_CNTI;      // too costly: never flips
                    end else begin
                        r_state <= S_EXP;
                    end
                end
                S_EXP: begin
                    if (r_de[r_k]) begin
                        r_acc <= prod[48:24];
                    end
                    if (r_k == 4'd11) begin
                        r_state <= S_CMP;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                S_CMP: begin
                    r_flip  <= ({1'b0, r_uni} < prob);
                    r_state <= S_CNTI;
                end
                S_CNTI: begin
                    if (r_flip) begin
                        r_spins[site_idx] <= ~spin_st;
                    end
                    r_cnt    <= '0;
                    r_issue  <= 1'b1;
                    r_rd_vld <= 1'b0;
                    r_state  <= S_CNT;
                end
                S_CNT: begin
                    if (r_rd_vld && r_rd_j == LAST) begin
                        r_state <= S_RES;
                    end
                end
                S_RD: begin
                    if (r_kind == mbsu_pkg::K_READ_SITE) begin
                        r_count <= site_rdata;
                    end else if (r_pt_ok) begin
                        r_count <= pair_rdata[pt_idx*CNT_W +: CNT_W];
                    end
                    r_state <= S_RES;
                end
                S_RES: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid <= 1'b1;
                        o_accepted  <= r_site_ok && (r_kind == mbsu_pkg::K_STEP) && r_flip;
                        o_spin_now  <= r_site_ok && spin_st;
                        o_count_out <= r_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
